@@ design/tdos_pkg.sv @@
package tdos_pkg;

    localparam int CAPACITY = 64;
    localparam int SLOT_W   = 6;
    localparam int CNT_W    = 7;
    localparam int FLAG_W   = 14;
    localparam int ENTRY_W  = FLAG_W + 31 + 32 + 16;

    localparam logic [1:0]  HANG_UP     = 2'd1;
    localparam logic [1:0]  HANG_SHADOW = 2'd2;
    localparam logic [1:0]  KIND_SPRITE = 2'd1;
    localparam logic [22:0] ALPHA_ONE   = 23'd4096;

    typedef struct packed {
        logic [1:0]        hang;
        logic              trans;
        logic [1:0]        kind;
        logic signed [8:0] prio;
        logic [30:0]       dist_bits;
        logic [31:0]       id;
        logic [15:0]       lump;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FETCH,
        ST_CMP,
        ST_EMIT_RD,
        ST_EMIT
    } state_t;

    // True when a sorts strictly after b.
    function automatic logic sorts_after(entry_t a, entry_t b);
        logic ah, bh, as_, bs, skip;
        ah = (a.hang == HANG_UP);
        bh = (b.hang == HANG_UP);
        as_ = (a.hang == HANG_SHADOW);
        bs = (b.hang == HANG_SHADOW);
        skip = 1'b0;
        if (ah != bh) return bh;
        if (as_ != bs) return bs;
        if (a.trans && b.trans) begin
            if (a.dist_bits != b.dist_bits) return a.dist_bits < b.dist_bits;
            skip = 1'b1;
        end else if (a.trans != b.trans) begin
            return a.trans;
        end
        if (a.kind != b.kind) return a.kind > b.kind;
        if (!skip && a.dist_bits != b.dist_bits) return a.dist_bits > b.dist_bits;
        if (a.prio != b.prio) return a.prio < b.prio;
        if (a.id != b.id) return a.id > b.id;
        if (a.kind == KIND_SPRITE && a.lump != b.lump) return a.lump > b.lump;
        return 1'b0;
    endfunction

endpackage

@@ design/tdos_ram.sv @@
module tdos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

@@ design/translucent_draw_order_sorter_top.sv @@
// Channel | Dir | tdata (low bit up)                                         | tuser | tlast
// s_      | in  | hang_kind,additive,alpha,distance,kind,priority_req,       | -     | last
//         |     | object_id,lump (116 bits, padded to 120)                   |       |
// m_      | out | slot (6 bits, padded to 8)                                 | overflow | final_res
// Insertion: each step of the walk past a stored entry reads the order RAM, reads the entry
//   RAM and compares; the walk ends at the front or at the first entry that does not sort
//   after the new one. The next entry is taken only in the idle state.
// Emission: each result takes an order RAM read, then a result load; a final read state closes.
// Reset: aresetn clears count, overflow flag and state; RAM contents stay undefined.
// Stalls: m_tready low holds the result register; no input is taken while busy.
module translucent_draw_order_sorter_top
    import tdos_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [119:0] s_tdata,   // hang_kind,additive,alpha,distance,kind,priority_req,object_id,lump
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // slot
    output logic         m_tuser,   // overflow
    output logic         m_tlast
);
    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next, pos_reg, pos_next;
    logic dropped_reg, dropped_next, last_reg, last_next;
    entry_t new_reg, new_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] held_reg, held_next;
    logic mv_reg, mv_next, mfin_reg, mfin_next, movf_reg, movf_next;

    // entry RAM holds the attributes per arrival slot
    logic e_we;
    logic [SLOT_W-1:0] e_waddr, e_raddr;
    entry_t e_rdata;
    // order RAM holds the sorted slot list
    logic o_we;
    logic [SLOT_W-1:0] o_waddr, o_raddr, o_rdata, o_wdata;

    tdos_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_entry (
        .aclk(aclk), .we(e_we), .waddr(e_waddr), .wdata(new_reg),
        .raddr(e_raddr), .rdata(e_rdata));
    tdos_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_order (
        .aclk(aclk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
        .raddr(o_raddr), .rdata(o_rdata));

    entry_t in_e;
    always_comb begin
        in_e.hang      = s_tdata[1:0];
        in_e.trans     = s_tdata[2] || (s_tdata[25:3] < ALPHA_ONE);
        in_e.dist_bits = s_tdata[56:26];
        in_e.kind      = s_tdata[58:57];
        in_e.prio      = s_tdata[67:59];
        in_e.id        = s_tdata[99:68];
        in_e.lump      = s_tdata[115:100];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = {2'b00, slot_reg};
    assign m_tuser  = movf_reg;
    assign m_tlast  = mfin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            mv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            mv_reg      <= mv_next;
        end
        pos_reg  <= pos_next;
        last_reg <= last_next;
        new_reg  <= new_next;
        slot_reg <= slot_next;
        held_reg <= held_next;
        mfin_reg <= mfin_next;
        movf_reg <= movf_next;
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        dropped_next = dropped_reg;
        pos_next = pos_reg;
        last_next = last_reg;
        new_next = new_reg;
        slot_next = slot_reg;
        held_next = held_reg;
        mv_next = mv_reg;
        mfin_next = mfin_reg;
        movf_next = movf_reg;
        e_we = 1'b0;
        e_waddr = count_reg[SLOT_W-1:0];
        e_raddr = o_rdata;
        o_we = 1'b0;
        o_waddr = pos_reg[SLOT_W-1:0];
        o_wdata = held_reg;
        o_raddr = pos_reg[SLOT_W-1:0] - 1'b1;
        if (mv_reg && m_tready) mv_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    new_next  = in_e;
                    last_next = s_tlast;
                    pos_next  = count_reg;
                    if (count_reg < CNT_W'(CAPACITY)) begin
                        state_next = ST_READ;
                    end else begin
                        // full: drop the entry, still close the batch on last
                        dropped_next = 1'b1;
                        pos_next = '0;
                        state_next = s_tlast ? ST_EMIT_RD : ST_IDLE;
                    end
                end
            end
            ST_READ: begin
                // write the entry on the first pass, fetch order[pos-1]
                e_we = (pos_reg == count_reg);
                if (pos_reg == '0) begin
                    o_we = 1'b1;
                    o_wdata = count_reg[SLOT_W-1:0];
                    count_next = count_reg + 1'b1;
                    state_next = last_reg ? ST_EMIT_RD : ST_IDLE;
                end else begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                // order word is here; fetch the entry it points at
                held_next = o_rdata;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                o_we = 1'b1;
                if (sorts_after(e_rdata, new_reg)) begin
                    // shift the stored slot up one place and walk on
                    o_wdata = held_reg;
                    pos_next = pos_reg - 1'b1;
                    state_next = ST_READ;
                end else begin
                    o_wdata = count_reg[SLOT_W-1:0];
                    count_next = count_reg + 1'b1;
                    pos_next = '0;
                    state_next = last_reg ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                o_raddr = pos_reg[SLOT_W-1:0];
                if (pos_reg == count_reg) begin
                    count_next = '0;
                    dropped_next = 1'b0;
                    state_next = ST_IDLE;
                end else if (!mv_reg || m_tready) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                mv_next = 1'b1;
                slot_next = o_rdata;
                mfin_next = (pos_reg + 1'b1 == count_reg);
                movf_next = dropped_reg;
                pos_next = pos_reg + 1'b1;
                state_next = ST_EMIT_RD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY)) else $error("count beyond capacity");
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("ready while busy");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(slot_reg)))
        else $error("result changed under stall");
    a_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> (pos_reg != '0)) else $error("walk below zero");
`endif
endmodule

@@ test/translucent_draw_order_sorter_top_tb.sv @@
module translucent_draw_order_sorter_top_tb
    import tdos_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [5:0] slot;
        logic       final_res;
        logic       overflow;
    } sorted_slot_t;

    typedef struct {
        logic [1:0]        hang;
        logic              trans;
        logic [1:0]        kind;
        logic signed [8:0] prio;
        logic [30:0]       dist_bits;
        logic [31:0]       id;
        logic [15:0]       lump;
    } draw_entry_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;   // hang_kind,additive,alpha,distance,kind,priority_req,object_id,lump
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;   // slot
    logic         m_tuser;   // overflow
    logic         m_tlast;

    translucent_draw_order_sorter_top uut (.*);

    // Shadow copy of the sorter state
    draw_entry_t  batch_entries [CAPACITY];
    logic [5:0]   batch_order [CAPACITY];
    int           batch_count;
    logic         batch_dropped;
    sorted_slot_t expected_slots [$];

    int  mismatch_count;
    int  result_count;
    int  cycle_count;
    int  batch_total;
    int  overflow_batches;
    int  rx_wait;
    bit  hold_results;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abort the run if the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("Mismatch at result %0d: %s got %0d expected %0d",
                 result_count, what, got, want);
        mismatch_count++;
    endtask

    // True when a sorts strictly after b
    function automatic bit draws_later(draw_entry_t a, draw_entry_t b);
        bit skip_near;
        skip_near = 1'b0;
        if ((a.hang == HANG_UP) != (b.hang == HANG_UP)) return b.hang == HANG_UP;
        if ((a.hang == HANG_SHADOW) != (b.hang == HANG_SHADOW)) return b.hang == HANG_SHADOW;
        if (a.trans && b.trans) begin
            if (a.dist_bits != b.dist_bits) return a.dist_bits < b.dist_bits;
            skip_near = 1'b1;
        end else if (a.trans != b.trans) begin
            return a.trans;
        end
        if (a.kind != b.kind) return a.kind > b.kind;
        if (!skip_near && a.dist_bits != b.dist_bits) return a.dist_bits > b.dist_bits;
        if (a.prio != b.prio) return a.prio < b.prio;
        if (a.id != b.id) return a.id > b.id;
        if (a.kind == KIND_SPRITE && a.lump != b.lump) return a.lump > b.lump;
        return 1'b0;
    endfunction

    // Insert one entry into the shadow order; emit the batch on last
    task automatic predict_draw_order(input logic [119:0] data, input logic last);
        draw_entry_t e;
        int pos;
        sorted_slot_t r;
        if (batch_count < CAPACITY) begin
            e.hang      = data[1:0];
            e.trans     = data[2] || (data[25:3] < ALPHA_ONE);
            e.dist_bits = data[56:26];
            e.kind      = data[58:57];
            e.prio      = data[67:59];
            e.id        = data[99:68];
            e.lump      = data[115:100];
            batch_entries[batch_count] = e;
            pos = batch_count;
            while (pos > 0 && draws_later(batch_entries[batch_order[pos-1]], e)) begin
                batch_order[pos] = batch_order[pos-1];
                pos--;
            end
            batch_order[pos] = batch_count[5:0];
            batch_count++;
        end else begin
            batch_dropped = 1'b1;
        end
        if (last) begin
            for (int k = 0; k < batch_count; k++) begin
                r.slot      = batch_order[k];
                r.final_res = (k + 1 == batch_count);
                r.overflow  = batch_dropped;
                expected_slots.push_back(r);
            end
            batch_total++;
            if (batch_dropped) overflow_batches++;
            batch_count   = 0;
            batch_dropped = 1'b0;
        end
    endtask

    // Offer one transaction after a random gap; predict on acceptance
    task automatic send_entry(input logic [119:0] data, input logic last);
        int gap;
        gap = $urandom_range(0, 12) * $urandom_range(0, 1);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_draw_order(data, last);
    endtask

    function automatic logic [119:0] pack_entry(logic [1:0] hang, logic add,
            logic [22:0] alpha, logic [30:0] dist_bits, logic [1:0] kind,
            logic [8:0] prio, logic [31:0] id, logic [15:0] lump);
        return {4'b0, lump, id, prio, kind, dist_bits, alpha, add, hang};
    endfunction

    function automatic logic [119:0] random_entry();
        logic [22:0] alpha;
        logic [30:0] dist_bits;
        // Bias toward the threshold and repeated values so ties occur
        case ($urandom_range(0, 3))
            0: alpha = ALPHA_ONE - 23'($urandom_range(0, 1));
            1: alpha = 23'($urandom_range(0, 8191));
            default: alpha = 23'($urandom);
        endcase
        dist_bits = ($urandom_range(0, 2) == 0) ? 31'($urandom_range(0, 3)) : 31'($urandom);
        return pack_entry(2'($urandom), 1'($urandom), alpha, dist_bits, 2'($urandom),
                          9'($urandom), ($urandom_range(0, 1) ? 32'($urandom_range(0, 3))
                                                            : 32'($urandom)),
                          16'($urandom));
    endfunction

    // Wait until every expectation has been seen, plus a margin
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_slots.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    // Receiver: wait a random count of cycles before each result, long hold when requested
    always @(posedge aclk) begin
        if (!aresetn || hold_results) begin
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            rx_wait = $urandom_range(0, 12);
            m_tready <= (rx_wait == 0);
        end else if (rx_wait != 0) begin
            rx_wait--;
            m_tready <= (rx_wait == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        sorted_slot_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_slots.size() == 0) begin
                report_mismatch("unexpected result, slot", m_tdata, -1);
            end else begin
                want = expected_slots.pop_front();
                if (m_tdata != {2'b0, want.slot}) report_mismatch("slot", m_tdata, want.slot);
                if (m_tlast != want.final_res)
                    report_mismatch("final_res", m_tlast, want.final_res);
                if (m_tuser != want.overflow)
                    report_mismatch("overflow", m_tuser, want.overflow);
            end
            result_count++;
        end
    end

    // Extremes of most fields, each ordering key, single-entry batch
    task automatic test_directed();
        send_entry(pack_entry(2'd0, 1'b0, 23'd4096, 31'd0, 2'd0, 9'h0FF, 32'd5, 16'd0), 1'b1);
        send_entry(pack_entry(2'd0, 1'b0, 23'h7FFFFF, 31'h7F800000, 2'd2, 9'h100,
                              32'hFFFFFFFF, 16'hFFFF), 1'b0);
        send_entry(pack_entry(2'd1, 1'b0, 23'd4096, 31'd10, 2'd0, 9'd0, 32'd1, 16'd0), 1'b0);
        send_entry(pack_entry(2'd2, 1'b0, 23'd4096, 31'd10, 2'd0, 9'd0, 32'd1, 16'd0), 1'b0);
        send_entry(pack_entry(2'd3, 1'b0, 23'd4096, 31'd10, 2'd3, 9'd0, 32'd1, 16'd3), 1'b0);
        send_entry(pack_entry(2'd0, 1'b1, 23'h7FFFFF, 31'd50, 2'd1, 9'd0, 32'd1, 16'd0), 1'b0);
        send_entry(pack_entry(2'd0, 1'b0, 23'd4095, 31'd50, 2'd0, 9'd0, 32'd1, 16'd0), 1'b0);
        send_entry(pack_entry(2'd0, 1'b0, 23'd0, 31'd90, 2'd2, 9'd0, 32'd1, 16'd0), 1'b0);
        send_entry(pack_entry(2'd0, 1'b0, 23'd4096, 31'd20, 2'd1, 9'd3, 32'd7, 16'd9), 1'b0);
        send_entry(pack_entry(2'd0, 1'b0, 23'd4096, 31'd20, 2'd1, 9'd3, 32'd7, 16'd2), 1'b0);
        send_entry(pack_entry(2'd0, 1'b0, 23'd4096, 31'd20, 2'd1, 9'd3, 32'd7, 16'd2), 1'b0);
        send_entry(pack_entry(2'd0, 1'b0, 23'd4096, 31'd20, 2'd1, 9'h1FF, 32'd7, 16'd2), 1'b0);
        send_entry(pack_entry(2'd0, 1'b0, 23'd4096, 31'd20, 2'd0, 9'd3, 32'd6, 16'd2), 1'b0);
        send_entry(pack_entry(2'd0, 1'b0, 23'd4096, 31'd20, 2'd0, 9'd3, 32'd8, 16'd1), 1'b1);
        drain_results();
    endtask

    // Overfill a batch, then hold the receiver off while it emits and more entries wait
    task automatic test_overflow_with_hold();
        for (int i = 0; i < CAPACITY + 2; i++) send_entry(random_entry(), 1'b0);
        hold_results = 1'b1;
        fork
            begin
                repeat (400) @(posedge aclk);
                hold_results = 1'b0;
            end
        join_none
        send_entry(random_entry(), 1'b1);
        for (int i = 0; i < 4; i++) send_entry(random_entry(), i == 3);
        drain_results();
    endtask

    // Random batches, mostly short
    task automatic test_random_batches();
        int sent;
        int len;
        sent = 0;
        while (sent < 65) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) send_entry(random_entry(), i == len - 1);
            sent += len;
        end
        drain_results();
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        hold_results   = 1'b0;
        mismatch_count = 0;
        result_count   = 0;
        cycle_count    = 0;
        batch_total    = 0;
        overflow_batches = 0;
        batch_count    = 0;
        batch_dropped  = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_overflow_with_hold();
        test_random_batches();

        $display("Covered %0d batches (%0d with dropped entries), %0d sorted results checked",
                 batch_total, overflow_batches, result_count);
        if (mismatch_count == 0 && expected_slots.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     expected_slots.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
